/* src/cspe_pkg.sv */
// ----------------------------------------------------------------------------
// cspe_pkg
// Shared types and constants for the cubic spline point evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package cspe_pkg;

	// Default coordinate width and fraction bits (Q15.16)
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	// Evaluation modes
	typedef enum logic [1:0] {
		MODE_CR_POS = 2'd0,
		MODE_CR_TAN = 2'd1,
		MODE_HM_POS = 2'd2,
		MODE_HM_TAN = 2'd3
	} mode_t;

	// Load enables for a module that holds two pipeline stages
	typedef struct packed {
		logic s_first;
		logic s_second;
	} pipe_en_t;

endpackage

`default_nettype wire

/* src/cspe_req_if.sv */
// ----------------------------------------------------------------------------
// cspe_req_if
// Input channel: mode, curve parameter and four coordinate values per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface cspe_req_if #(
	parameter int CW = cspe_pkg::COORD_WIDTH_DEF,
	parameter int FB = cspe_pkg::FRAC_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [1:0]           mode;
	logic signed [FB+1:0] param_t;
	logic signed [CW-1:0] val_a;
	logic signed [CW-1:0] val_b;
	logic signed [CW-1:0] val_c;
	logic signed [CW-1:0] val_d;

	modport source (output valid, mode, param_t, val_a, val_b, val_c, val_d,
		input ready);
	modport sink (input valid, mode, param_t, val_a, val_b, val_c, val_d,
		output ready);
endinterface

`default_nettype wire

/* src/cspe_rsp_if.sv */
// ----------------------------------------------------------------------------
// cspe_rsp_if
// Output channel: evaluated coordinate and in-range flag per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface cspe_rsp_if #(
	parameter int CW = cspe_pkg::COORD_WIDTH_DEF
);
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] result_value;
	logic                 in_range;

	modport source (output valid, result_value, in_range, input ready);
	modport sink (input valid, result_value, in_range, output ready);
endinterface

`default_nettype wire

/* src/cspe_coef.sv */
// ----------------------------------------------------------------------------
// cspe_coef
// Two pipeline stages: range check and operand prep, then the cubic
// coefficients in Horner order (c3 innermost), all at twice the scale.
// ----------------------------------------------------------------------------
`default_nettype none

module cspe_coef #(
	parameter int CW = cspe_pkg::COORD_WIDTH_DEF,
	parameter int FB = cspe_pkg::FRAC_BITS_DEF,
	parameter int RW = CW + 8,
	parameter int TW = FB + 1
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  cspe_pkg::pipe_en_t         en,
	input  wire [1:0]                  mode,
	input  wire signed [FB+1:0]        param_t,
	input  wire signed [CW-1:0]        val_a,
	input  wire signed [CW-1:0]        val_b,
	input  wire signed [CW-1:0]        val_c,
	input  wire signed [CW-1:0]        val_d,
	output logic signed [RW-1:0]       c0,
	output logic signed [RW-1:0]       c1,
	output logic signed [RW-1:0]       c2,
	output logic signed [RW-1:0]       c3,
	output logic [TW-1:0]              t_val,
	output logic                       in_range
);

	localparam logic [FB:0] T_ONE = {1'b1, {FB{1'b0}}};

	logic                 hermite;
	logic                 tangent;
	logic                 t_neg;
	logic                 t_above;
	logic signed [CW-1:0] seg_start;
	logic signed [CW-1:0] seg_end;
	logic signed [CW-1:0] sel_pt;
	logic signed [CW:0]   p0_c;
	logic signed [CW+1:0] dp_c;
	logic signed [CW:0]   m0_c;
	logic signed [CW:0]   m1_c;

	logic signed [CW:0]   p0_s1;
	logic signed [CW+1:0] dp_s1;
	logic signed [CW:0]   m0_s1;
	logic signed [CW:0]   m1_s1;
	logic [TW-1:0]        t_s1;
	logic                 tangent_s1;
	logic                 in_range_s1;

	logic signed [RW-1:0] p0x;
	logic signed [RW-1:0] dpx;
	logic signed [RW-1:0] m0x;
	logic signed [RW-1:0] m1x;
	logic signed [RW-1:0] a2_c;
	logic signed [RW-1:0] a3_c;

	logic signed [RW-1:0] c0_s2;
	logic signed [RW-1:0] c1_s2;
	logic signed [RW-1:0] c2_s2;
	logic signed [RW-1:0] c3_s2;
	logic [TW-1:0]        t_s2;
	logic                 in_range_s2;

	// Mode decode
	always_comb begin
		unique case (cspe_pkg::mode_t'(mode))
			cspe_pkg::MODE_CR_POS: begin hermite = 1'b0; tangent = 1'b0; end
			cspe_pkg::MODE_CR_TAN: begin hermite = 1'b0; tangent = 1'b1; end
			cspe_pkg::MODE_HM_POS: begin hermite = 1'b1; tangent = 1'b0; end
			cspe_pkg::MODE_HM_TAN: begin hermite = 1'b1; tangent = 1'b1; end
			default:               begin hermite = 1'b0; tangent = 1'b0; end
		endcase
	end

	// Range check and doubled operands
	always_comb begin
		t_neg     = param_t[FB+1];
		t_above   = !t_neg && (param_t[FB:0] > T_ONE);
		seg_start = hermite ? val_a : val_b;
		seg_end   = hermite ? val_b : val_c;
		// Out of range returns an endpoint: carried as p0, rest zeroed later
		sel_pt    = t_above ? seg_end : seg_start;
		p0_c      = {sel_pt, 1'b0};
		dp_c      = {({seg_end[CW-1], seg_end} - {seg_start[CW-1], seg_start}), 1'b0};
		m0_c      = hermite ? {val_c, 1'b0} : ({val_c[CW-1], val_c} - {val_a[CW-1], val_a});
		m1_c      = hermite ? {val_d, 1'b0} : ({val_d[CW-1], val_d} - {val_b[CW-1], val_b});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_range_s1 <= 1'b1;
			in_range_s2 <= 1'b1;
		end else begin
			if (en.s_first) begin
				in_range_s1 <= !t_neg && !t_above;
			end
			if (en.s_second) begin
				in_range_s2 <= in_range_s1;
			end
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (en.s_first) begin
			p0_s1      <= p0_c;
			dp_s1      <= dp_c;
			m0_s1      <= m0_c;
			m1_s1      <= m1_c;
			t_s1       <= (t_neg || t_above) ? '0 : param_t[FB:0];
			tangent_s1 <= tangent;
		end
	end

	// Coefficients: a2 = 3dp - 2m0 - m1, a3 = m0 + m1 - 2dp
	always_comb begin
		p0x  = RW'(p0_s1);
		dpx  = RW'(dp_s1);
		m0x  = RW'(m0_s1);
		m1x  = RW'(m1_s1);
		a3_c = m0x + m1x - (dpx <<< 1);
		a2_c = (dpx <<< 1) + dpx - (m0x <<< 1) - m1x;
	end

	// Stage 2 payload: Horner coefficients per mode
	always_ff @(posedge clk) begin
		if (en.s_second) begin
			t_s2 <= t_s1;
			if (!in_range_s1) begin
				c3_s2 <= '0;
				c2_s2 <= '0;
				c1_s2 <= '0;
				c0_s2 <= p0x;
			end else if (tangent_s1) begin
				c3_s2 <= '0;
				c2_s2 <= (a3_c <<< 1) + a3_c;
				c1_s2 <= a2_c <<< 1;
				c0_s2 <= m0x;
			end else begin
				c3_s2 <= a3_c;
				c2_s2 <= a2_c;
				c1_s2 <= m0x;
				c0_s2 <= p0x;
			end
		end
	end

	assign c0       = c0_s2;
	assign c1       = c1_s2;
	assign c2       = c2_s2;
	assign c3       = c3_s2;
	assign t_val    = t_s2;
	assign in_range = in_range_s2;

	// Clamped items carry only the endpoint
	a_clamp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!in_range_s2 |-> (c3_s2 == '0) && (c2_s2 == '0) && (c1_s2 == '0))
		else $error("clamped item has nonzero higher coefficients");

endmodule

`default_nettype wire

/* src/cspe_hstep.sv */
// ----------------------------------------------------------------------------
// cspe_hstep
// One Horner step over two stages: acc_next = coef + round(acc * t / 2^FB),
// rounding half away from zero. Stage 1 multiplies magnitudes, stage 2
// rounds, restores the sign and adds.
// ----------------------------------------------------------------------------
`default_nettype none

module cspe_hstep #(
	parameter int FB = cspe_pkg::FRAC_BITS_DEF,
	parameter int RW = cspe_pkg::COORD_WIDTH_DEF + 8,
	parameter int TW = FB + 1,
	parameter int PW = 1
) (
	input  wire                   clk,
	input  cspe_pkg::pipe_en_t    en,
	input  wire signed [RW-1:0]   acc,
	input  wire signed [RW-1:0]   coef,
	input  wire [TW-1:0]          t_val,
	input  wire [PW-1:0]          side,
	output logic signed [RW-1:0]  acc_next,
	output logic [TW-1:0]         t_next,
	output logic [PW-1:0]         side_next
);

	localparam int PRW = RW + TW;
	localparam logic [PRW-1:0] HALF = PRW'(1) << (FB - 1);

	logic [RW-1:0]        mag_c;
	logic [PRW-1:0]       prod_c;
	logic [PRW-1:0]       prod_s1;
	logic                 neg_s1;
	logic signed [RW-1:0] coef_s1;
	logic [TW-1:0]        t_s1;
	logic [PW-1:0]        side_s1;

	logic [PRW-1:0]       rnd_c;
	logic [RW-1:0]        rmag_c;
	logic signed [RW-1:0] term_c;
	logic signed [RW-1:0] acc_s2;
	logic [TW-1:0]        t_s2;
	logic [PW-1:0]        side_s2;

	// Magnitude times t
	always_comb begin
		mag_c  = acc[RW-1] ? (~acc + 1'b1) : acc;
		prod_c = {{TW{1'b0}}, mag_c} * {{RW{1'b0}}, t_val};
	end

	always_ff @(posedge clk) begin
		if (en.s_first) begin
			prod_s1 <= prod_c;
			neg_s1  <= acc[RW-1];
			coef_s1 <= coef;
			t_s1    <= t_val;
			side_s1 <= side;
		end
	end

	// Round, sign and accumulate; |term| never exceeds |acc| since t <= one
	always_comb begin
		rnd_c  = (prod_s1 + HALF) >> FB;
		rmag_c = rnd_c[RW-1:0];
		term_c = neg_s1 ? $signed(~rmag_c + 1'b1) : $signed(rmag_c);
	end

	always_ff @(posedge clk) begin
		if (en.s_second) begin
			acc_s2  <= coef_s1 + term_c;
			t_s2    <= t_s1;
			side_s2 <= side_s1;
		end
	end

	assign acc_next  = acc_s2;
	assign t_next    = t_s2;
	assign side_next = side_s2;

endmodule

`default_nettype wire

/* src/cspe_round_sat.sv */
// ----------------------------------------------------------------------------
// cspe_round_sat
// Output stage: halves the doubled sum (half away from zero), saturates to
// the coordinate width and holds the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module cspe_round_sat #(
	parameter int CW = cspe_pkg::COORD_WIDTH_DEF,
	parameter int RW = CW + 8
) (
	input  wire                   clk,
	input  wire                   load,
	input  wire signed [RW-1:0]   acc,
	input  wire                   in_range,
	output logic signed [CW-1:0]  result_value,
	output logic                  result_in_range
);

	localparam logic signed [RW-1:0] SAT_HI = {{(RW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

	logic [RW-1:0]        mag_c;
	logic [RW:0]          inc_c;
	logic [RW-1:0]        half_c;
	logic signed [RW-1:0] val_c;
	logic signed [CW-1:0] sat_c;
	logic signed [CW-1:0] value_s1;
	logic                 in_range_s1;

	always_comb begin
		mag_c  = acc[RW-1] ? (~acc + 1'b1) : acc;
		inc_c  = {1'b0, mag_c} + 1'b1;
		half_c = inc_c[RW:1];
		val_c  = acc[RW-1] ? $signed(~half_c + 1'b1) : $signed(half_c);
		if (val_c > SAT_HI) begin
			sat_c = SAT_HI[CW-1:0];
		end else if (val_c < SAT_LO) begin
			sat_c = SAT_LO[CW-1:0];
		end else begin
			sat_c = val_c[CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_s1    <= sat_c;
			in_range_s1 <= in_range;
		end
	end

	assign result_value    = value_s1;
	assign result_in_range = in_range_s1;

endmodule

`default_nettype wire

/* src/cubic_spline_point_eval.sv */
// ----------------------------------------------------------------------------
// cubic_spline_point_eval
// One-axis Catmull-Rom / cubic Hermite segment evaluator, position or slope.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output is not stalled and returns one
// result item per item, in order. The pipeline is two coefficient stages,
// three Horner steps of one multiplier stage plus one round-and-add stage
// each, and an output register that rounds and saturates. Every stage holds
// its item under back-pressure and empty stages keep filling, so a waiting
// result stops new items from entering only once every stage is full.
// Parameters t outside 0..one return the segment endpoint with in_range low.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_spline_point_eval #(
	parameter int COORD_WIDTH = cspe_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = cspe_pkg::FRAC_BITS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	cspe_req_if.sink   req,
	cspe_rsp_if.source rsp
);

	localparam int RW     = COORD_WIDTH + 8;
	localparam int TW     = FRAC_BITS + 1;
	localparam int NSTAGE = 9;

	logic [NSTAGE-1:0] valid_q;
	logic [NSTAGE-1:0] stage_en;

	logic signed [RW-1:0] c0, c1, c2, c3;
	logic [TW-1:0]        t0, t1, t2, t3;
	logic                 rng0;
	logic signed [RW-1:0] acc1, acc2, acc3;
	logic [2*RW:0]        side1;
	logic [RW:0]          side2;
	logic [0:0]           side3;

	// Stage enables: a stage loads when empty or when its successor moves
	always_comb begin
		stage_en[NSTAGE-1] = !valid_q[NSTAGE-1] || rsp.ready;
		for (int k = NSTAGE - 2; k >= 0; k--) begin
			stage_en[k] = !valid_q[k] || stage_en[k+1];
		end
	end

	// Valid bits travel with the items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (stage_en[0]) begin
				valid_q[0] <= req.valid;
			end
			for (int k = 1; k < NSTAGE; k++) begin
				if (stage_en[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign req.ready = stage_en[0];
	assign rsp.valid = valid_q[NSTAGE-1];

	cspe_coef #(.CW(COORD_WIDTH), .FB(FRAC_BITS), .RW(RW), .TW(TW)) u_coef (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       ('{s_first: stage_en[0], s_second: stage_en[1]}),
		.mode     (req.mode),
		.param_t  (req.param_t),
		.val_a    (req.val_a),
		.val_b    (req.val_b),
		.val_c    (req.val_c),
		.val_d    (req.val_d),
		.c0       (c0),
		.c1       (c1),
		.c2       (c2),
		.c3       (c3),
		.t_val    (t0),
		.in_range (rng0)
	);

	// Horner steps: c3 -> +c2 -> +c1 -> +c0
	cspe_hstep #(.FB(FRAC_BITS), .RW(RW), .TW(TW), .PW(2*RW+1)) u_step1 (
		.clk       (clk),
		.en        ('{s_first: stage_en[2], s_second: stage_en[3]}),
		.acc       (c3),
		.coef      (c2),
		.t_val     (t0),
		.side      ({c1, c0, rng0}),
		.acc_next  (acc1),
		.t_next    (t1),
		.side_next (side1)
	);

	cspe_hstep #(.FB(FRAC_BITS), .RW(RW), .TW(TW), .PW(RW+1)) u_step2 (
		.clk       (clk),
		.en        ('{s_first: stage_en[4], s_second: stage_en[5]}),
		.acc       (acc1),
		.coef      ($signed(side1[2*RW:RW+1])),
		.t_val     (t1),
		.side      (side1[RW:0]),
		.acc_next  (acc2),
		.t_next    (t2),
		.side_next (side2)
	);

	cspe_hstep #(.FB(FRAC_BITS), .RW(RW), .TW(TW), .PW(1)) u_step3 (
		.clk       (clk),
		.en        ('{s_first: stage_en[6], s_second: stage_en[7]}),
		.acc       (acc2),
		.coef      ($signed(side2[RW:1])),
		.t_val     (t2),
		.side      (side2[0:0]),
		.acc_next  (acc3),
		.t_next    (t3),
		.side_next (side3)
	);

	cspe_round_sat #(.CW(COORD_WIDTH), .RW(RW)) u_round_sat (
		.clk             (clk),
		.load            (stage_en[NSTAGE-1] && (t3 == t3)),
		.acc             (acc3),
		.in_range        (side3[0]),
		.result_value    (rsp.result_value),
		.result_in_range (rsp.in_range)
	);

	// An empty output register means the whole pipeline can move
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp.valid |-> req.ready)
		else $error("input stalled while output register is empty");

	// A full pipeline under back-pressure takes nothing new
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		((&valid_q) && !rsp.ready) |-> !req.ready)
		else $error("item accepted into a full stalled pipeline");

	// Accepted item lands in the first stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> valid_q[0])
		else $error("accepted item lost at pipeline entry");

endmodule

`default_nettype wire
